// ===== hdl/flst_pkg.sv =====
// flst_pkg: types and constants of the free-list slot allocator.
// Used by flst_link_mem, flst_offset and free_list_slot_allocator.
package flst_pkg;

  localparam int unsigned DefMaxSlots = 1024;
  localparam int unsigned LinkW       = 10;
  localparam int unsigned SizeW       = 13;
  localparam int unsigned LimitW      = 11;
  localparam int unsigned OffsetW     = 22;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned SizeCap     = 4096;
  localparam int unsigned SizeReset   = 8;
  localparam int unsigned LimitReset  = 1024;

  typedef enum logic [1:0] {
    STATUS_LIST      = 2'd0,
    STATUS_FRESH     = 2'd1,
    STATUS_EXHAUSTED = 2'd2,
    STATUS_FREED     = 2'd3
  } status_e;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLOT_BYTES = 1'b0,
    CFG_SLOT_LIMIT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  // one link entry: end-of-list mark and next slot
  typedef struct packed {
    logic             last;
    logic [LinkW-1:0] next;
  } link_t;

endpackage

// ===== hdl/flst_link_mem.sv =====
// flst_link_mem: synchronous link memory of the free list, one write and
// one read port with a registered read output. Depends on flst_pkg.
module flst_link_mem #(
  parameter int unsigned MAX_SLOTS = flst_pkg::DefMaxSlots
) (
  input  logic                         clk_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] wr_addr_i,
  input  flst_pkg::link_t              wr_data_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] rd_addr_i,
  output flst_pkg::link_t              rd_data_o
);

  flst_pkg::link_t mem_q [MAX_SLOTS];
  flst_pkg::link_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/flst_offset.sv =====
// flst_offset: byte offset of a slot, slot index times the clamped slot size,
// kept to the offset width. Depends on flst_pkg.
module flst_offset (
  input  logic [flst_pkg::LinkW-1:0]   slot_i,
  input  logic [flst_pkg::SizeW-1:0]   slot_bytes_i,
  output logic [flst_pkg::OffsetW-1:0] offset_o
);

  logic [flst_pkg::SizeW-1:0]             size_clamped;
  logic [flst_pkg::LinkW+flst_pkg::SizeW-1:0] product;

  always_comb begin
    size_clamped = (slot_bytes_i > flst_pkg::SizeW'(flst_pkg::SizeCap))
                 ? flst_pkg::SizeW'(flst_pkg::SizeCap) : slot_bytes_i;
    product  = (flst_pkg::LinkW+flst_pkg::SizeW)'(slot_i)
             * (flst_pkg::LinkW+flst_pkg::SizeW)'(size_clamped);
    offset_o = product[flst_pkg::OffsetW-1:0];
  end

endmodule

// ===== hdl/free_list_slot_allocator.sv =====
// free_list_slot_allocator: fixed-size slot allocator with a LIFO free list.
// Depends on flst_pkg, flst_link_mem and flst_offset.
//
// Usage:
//   Command channel: a transaction is taken at a rising edge with start
//   high and busy low. cmd_i selects allocate or free; slot_index_i is
//   the slot to free. Every command gives exactly one result.
//   Result channel: result_valid_o is high for one cycle with status_o,
//   given_slot_o and byte_offset_o. The receiver cannot stall; results are
//   never held.
//   Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 slot size,
//   1 slot limit) and cfg_data_i. cfg_ready_o is always high; write only
//   while no command is in flight.
// Timing:
//   Busy is high for the cycle after the transaction, and the result
//   appears in the cycle after that. No new command is taken while busy;
//   the head pop reads the next link from the link memory, whose
//   registered read output is why each command passes through the busy state.
// Reset:
//   The free list is empty, the bump counter is zero, slot size is 8 and
//   slot limit 1024. The link memory is not cleared; no pass runs.
module free_list_slot_allocator #(
  parameter int unsigned MAX_SLOTS = flst_pkg::DefMaxSlots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [flst_pkg::LinkW-1:0]     slot_index_i,
  output logic                           result_valid_o,
  output logic [1:0]                     status_o,
  output logic [flst_pkg::LinkW-1:0]     given_slot_o,
  output logic [flst_pkg::OffsetW-1:0]   byte_offset_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [flst_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [flst_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned AddrW  = $clog2(MAX_SLOTS);
  localparam int unsigned CountW = $clog2(MAX_SLOTS + 1);

  flst_pkg::state_e               state_q, state_d;
  logic                           accept;
  logic                           cmd_q;
  logic [flst_pkg::LinkW-1:0]     idx_q;
  logic [flst_pkg::SizeW-1:0]     slot_bytes_q;
  logic [flst_pkg::LimitW-1:0]    slot_limit_q;
  logic [flst_pkg::LinkW-1:0]     head_q, head_d;
  logic                           nonempty_q, nonempty_d;
  logic [CountW-1:0]              bump_q, bump_d;
  logic [CountW-1:0]              limit;
  logic                           wr_en;
  flst_pkg::link_t                wr_data;
  flst_pkg::link_t                rd_data;
  flst_pkg::status_e              status_d;
  logic [flst_pkg::LinkW-1:0]     slot_d;
  logic [flst_pkg::OffsetW-1:0]   offset_d;
  logic                           valid_q;
  flst_pkg::status_e              status_q;
  logic [flst_pkg::LinkW-1:0]     slot_q;
  logic [flst_pkg::OffsetW-1:0]   offset_q;

  assign busy        = (state_q == flst_pkg::ST_BUSY);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    case (state_q)
      flst_pkg::ST_IDLE: state_d = accept ? flst_pkg::ST_BUSY : flst_pkg::ST_IDLE;
      flst_pkg::ST_BUSY: state_d = flst_pkg::ST_IDLE;
      default:           state_d = flst_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= flst_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      idx_q <= slot_index_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_bytes_q <= flst_pkg::SizeW'(flst_pkg::SizeReset);
      slot_limit_q <= flst_pkg::LimitW'(flst_pkg::LimitReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        flst_pkg::CFG_SLOT_BYTES: slot_bytes_q <= cfg_data_i;
        flst_pkg::CFG_SLOT_LIMIT: slot_limit_q <= cfg_data_i[flst_pkg::LimitW-1:0];
        default: ;
      endcase
    end
  end

  flst_link_mem #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_link_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AddrW'(idx_q)),
    .wr_data_i (wr_data),
    .rd_en_i   (accept),
    .rd_addr_i (AddrW'(head_q)),
    .rd_data_o (rd_data)
  );

  always_comb begin
    limit = (32'(slot_limit_q) > MAX_SLOTS) ? CountW'(MAX_SLOTS) : CountW'(slot_limit_q);
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    bump_d       = bump_q;
    wr_en        = 1'b0;
    wr_data.last = !nonempty_q;
    wr_data.next = head_q;
    status_d     = flst_pkg::STATUS_FREED;
    slot_d       = '0;
    if (busy) begin
      if (cmd_q == flst_pkg::CMD_FREE) begin
        if (32'(idx_q) < MAX_SLOTS) begin
          wr_en      = 1'b1;
          head_d     = idx_q;
          nonempty_d = 1'b1;
        end
      end else if (nonempty_q) begin
        status_d   = flst_pkg::STATUS_LIST;
        slot_d     = head_q;
        head_d     = rd_data.next;
        nonempty_d = !rd_data.last;
      end else if (bump_q < limit) begin
        status_d = flst_pkg::STATUS_FRESH;
        slot_d   = flst_pkg::LinkW'(bump_q);
        bump_d   = bump_q + CountW'(1);
      end else begin
        status_d = flst_pkg::STATUS_EXHAUSTED;
      end
    end
  end

  flst_offset u_offset (
    .slot_i       (slot_d),
    .slot_bytes_i (slot_bytes_q),
    .offset_o     (offset_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      nonempty_q <= 1'b0;
      bump_q     <= '0;
      valid_q    <= 1'b0;
    end else begin
      head_q     <= head_d;
      nonempty_q <= nonempty_d;
      bump_q     <= bump_d;
      valid_q    <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      status_q <= status_d;
      slot_q   <= slot_d;
      offset_q <= offset_d;
    end
  end

  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign given_slot_o   = slot_q;
  assign byte_offset_o  = offset_q;

  a_busy_one_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted command did not enter busy");

  a_result_follows_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o)
    else $error("no result after busy cycle");

  a_exhausted_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (status_o == flst_pkg::STATUS_EXHAUSTED ||
                       status_o == flst_pkg::STATUS_FREED)
    |-> (given_slot_o == '0) && (byte_offset_o == '0))
    else $error("nonzero slot on exhausted or free result");

  a_bump_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bump_q) <= MAX_SLOTS)
    else $error("bump counter beyond region");

endmodule

// ===== verif/flst_result_checker.sv =====
// flst_result_checker: watches the command, config and result channels of the
// slot allocator, predicts each result and compares it in order.
// Depends on flst_pkg; instantiated by free_list_slot_allocator_tb.
module flst_result_checker #(
  parameter int unsigned MaxSlots = flst_pkg::DefMaxSlots
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic                          cmd_i,
  input  logic [flst_pkg::LinkW-1:0]    slot_index_i,
  input  logic                          result_valid_i,
  input  logic [1:0]                    status_i,
  input  logic [flst_pkg::LinkW-1:0]    given_slot_i,
  input  logic [flst_pkg::OffsetW-1:0]  byte_offset_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [flst_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [flst_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    flst_pkg::status_e            status;
    logic [flst_pkg::LinkW-1:0]   slot;
    logic [flst_pkg::OffsetW-1:0] offset;
  } slot_result_t;

  flst_pkg::link_t             link_mem [MaxSlots];
  logic [flst_pkg::LinkW-1:0]  head;
  logic                        list_valid;
  logic [flst_pkg::LimitW-1:0] bump;
  logic [flst_pkg::SizeW-1:0]  slot_size;
  logic [flst_pkg::LimitW-1:0] slot_cap;
  slot_result_t                grants_q [$];
  int                          errors;

  function automatic logic [flst_pkg::OffsetW-1:0] offset_for(
      logic [flst_pkg::LinkW-1:0] slot);
    int unsigned sz;
    sz = (32'(slot_size) > flst_pkg::SizeCap) ? flst_pkg::SizeCap : 32'(slot_size);
    return flst_pkg::OffsetW'(32'(slot) * sz);
  endfunction

  // applies one command to the predicted allocator state
  function automatic slot_result_t serve(flst_pkg::cmd_e c,
                                         logic [flst_pkg::LinkW-1:0] idx);
    slot_result_t               r;
    logic [flst_pkg::LinkW-1:0] slot;
    int unsigned                lim;
    r = '{flst_pkg::STATUS_FREED, '0, '0};
    if (c == flst_pkg::CMD_FREE) begin
      if (32'(idx) < MaxSlots) begin
        link_mem[idx] = '{last: !list_valid, next: head};
        head = idx;
        list_valid = 1'b1;
      end
    end else if (list_valid) begin
      slot = head;
      if (32'(slot) < MaxSlots) begin
        list_valid = !link_mem[slot].last;
        head = link_mem[slot].next;
      end else begin
        list_valid = 1'b0;
        head = '0;
      end
      r = '{flst_pkg::STATUS_LIST, slot, offset_for(slot)};
    end else begin
      lim = (32'(slot_cap) > MaxSlots) ? MaxSlots : 32'(slot_cap);
      if (32'(bump) < lim) begin
        r = '{flst_pkg::STATUS_FRESH, bump[flst_pkg::LinkW-1:0],
              offset_for(bump[flst_pkg::LinkW-1:0])};
        bump = bump + flst_pkg::LimitW'(1);
      end else begin
        r = '{flst_pkg::STATUS_EXHAUSTED, '0, '0};
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    slot_result_t want;
    if (!rst_ni) begin
      head = '0;
      list_valid = 1'b0;
      bump = '0;
      slot_size = flst_pkg::SizeW'(flst_pkg::SizeReset);
      slot_cap = flst_pkg::LimitW'(flst_pkg::LimitReset);
      grants_q.delete();
      errors = 0;
      pending_o <= 0;
      errors_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (grants_q.size() == 0) begin
          if (errors < 10) begin
            $display("%0t unexpected result: status %0d slot %0d offset %0d",
                     $realtime, status_i, given_slot_i, byte_offset_i);
          end
          errors++;
        end else begin
          want = grants_q.pop_front();
          if (status_i !== want.status || given_slot_i !== want.slot ||
              byte_offset_i !== want.offset) begin
            if (errors < 10) begin
              $display("%0t mismatch: status %0d/%0d slot %0d/%0d offset %0d/%0d (exp/got)",
                       $realtime, want.status, status_i, want.slot, given_slot_i,
                       want.offset, byte_offset_i);
            end
            errors++;
          end
        end
      end
      if (start_i && !busy_i) begin
        grants_q.push_back(serve(flst_pkg::cmd_e'(cmd_i), slot_index_i));
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (flst_pkg::cfg_idx_e'(cfg_index_i))
          flst_pkg::CFG_SLOT_BYTES: slot_size = cfg_data_i[flst_pkg::SizeW-1:0];
          flst_pkg::CFG_SLOT_LIMIT: slot_cap = cfg_data_i[flst_pkg::LimitW-1:0];
          default: ;
        endcase
      end
      pending_o <= grants_q.size();
      errors_o <= errors;
    end
  end

endmodule

// ===== verif/free_list_slot_allocator_tb.sv =====
// free_list_slot_allocator_tb: drives directed and random allocate/free
// traffic and config changes into the slot allocator and gives the verdict.
// Depends on flst_pkg, free_list_slot_allocator and flst_result_checker.
module free_list_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          cmd_i = flst_pkg::CMD_ALLOC;
  logic [flst_pkg::LinkW-1:0]    slot_index_i = '0;
  logic                          result_valid_o;
  logic [1:0]                    status_o;
  logic [flst_pkg::LinkW-1:0]    given_slot_o;
  logic [flst_pkg::OffsetW-1:0]  byte_offset_o;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [flst_pkg::CfgIdxW-1:0]  cfg_index_i = flst_pkg::CFG_SLOT_BYTES;
  logic [flst_pkg::CfgDataW-1:0] cfg_data_i = '0;

  int                  fail_count;
  int                  in_flight;
  int unsigned         cycles = 0;
  int unsigned         exhausted_seen = 0;

  free_list_slot_allocator dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .slot_index_i   (slot_index_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .given_slot_o   (given_slot_o),
    .byte_offset_o  (byte_offset_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  flst_result_checker result_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd_i),
    .slot_index_i   (slot_index_i),
    .result_valid_i (result_valid_o),
    .status_i       (status_o),
    .given_slot_i   (given_slot_o),
    .byte_offset_i  (byte_offset_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .errors_o       (fail_count),
    .pending_o      (in_flight)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (result_valid_o && status_o == flst_pkg::STATUS_EXHAUSTED) begin
      exhausted_seen <= exhausted_seen + 1;
    end
  end

  // one command transaction, preceded by a random gap
  task automatic issue(flst_pkg::cmd_e c, logic [flst_pkg::LinkW-1:0] idx, int idle_pct);
    while (int'($urandom_range(0, 99)) < idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    cmd_i = c;
    slot_index_i = idx;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    start = 1'b0;
  endtask

  task automatic write_reg(flst_pkg::cfg_idx_e idx, logic [flst_pkg::CfgDataW-1:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic drain();
    while (in_flight != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [flst_pkg::LinkW-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return flst_pkg::LinkW'($urandom_range(0, 15));
    if (r < 85) return flst_pkg::LinkW'($urandom);
    return (r < 92) ? '0 : '1;
  endfunction

  // bursts of allocates and frees; spread may skew each burst toward one kind
  task automatic run_mix(int n, int idle_pct, int alloc_pct, int spread,
                         bit until_exhausted);
    int          sent;
    int          burst;
    int          p;
    int unsigned base;
    sent = 0;
    base = exhausted_seen;
    while (sent < n && !(until_exhausted && exhausted_seen != base)) begin
      burst = $urandom_range(1, 12);
      p = alloc_pct + spread * (int'($urandom_range(0, 2)) - 1);
      repeat (burst) begin
        if (sent < n) begin
          if (int'($urandom_range(0, 99)) < p) begin
            issue(flst_pkg::CMD_ALLOC, flst_pkg::LinkW'($urandom), idle_pct);
          end else begin
            issue(flst_pkg::CMD_FREE, pick_index(), idle_pct);
          end
          sent++;
        end
      end
    end
  endtask

  initial begin
    int          idle_modes [3];
    int          limit_now;
    int          chunk;
    int unsigned base;
    logic [flst_pkg::SizeW-1:0] sz;
    idle_modes = '{0, 80, 27};
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset config: list order, end of list, double free, extreme slots
    issue(flst_pkg::CMD_ALLOC, '1, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_FREE, 10'd1, 0);
    issue(flst_pkg::CMD_FREE, 10'd0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_FREE, '1, 0);
    issue(flst_pkg::CMD_FREE, '1, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    drain();
    // oversize slot: capped, largest offset
    write_reg(flst_pkg::CFG_SLOT_BYTES, '1);
    issue(flst_pkg::CMD_FREE, '1, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    drain();
    write_reg(flst_pkg::CFG_SLOT_BYTES, '0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_FREE, 10'h2AA, 0);
    issue(flst_pkg::CMD_FREE, 10'h155, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    drain();
    // zero limit: only list pops succeed
    write_reg(flst_pkg::CFG_SLOT_LIMIT, '0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_FREE, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    drain();
    write_reg(flst_pkg::CFG_SLOT_LIMIT, flst_pkg::CfgDataW'(7));
    write_reg(flst_pkg::CFG_SLOT_BYTES, flst_pkg::CfgDataW'(flst_pkg::SizeCap));
    issue(flst_pkg::CMD_ALLOC, '0, 0);
    issue(flst_pkg::CMD_ALLOC, '0, 0);

    limit_now = 7;
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: sz = 13'd1;
        1: sz = flst_pkg::SizeW'(flst_pkg::SizeCap);
        3: sz = '1;
        4: sz = '0;
        default: sz = flst_pkg::SizeW'($urandom_range(1, 8191));
      endcase
      write_reg(flst_pkg::CFG_SLOT_BYTES, sz);
      if (ph == 2) begin
        write_reg(flst_pkg::CFG_SLOT_LIMIT, {2'($urandom), 11'd1});
      end else begin
        limit_now += $urandom_range(8, 48);
        write_reg(flst_pkg::CFG_SLOT_LIMIT, {2'($urandom), 11'(limit_now)});
      end
      run_mix(20, idle_modes[ph % 3], 50, 40, 1'b0);
      drain();
      run_mix(20, idle_modes[ph % 3], 50, 40, 1'b0);
    end

    // limit above the region: run the bump counter to saturation
    drain();
    write_reg(flst_pkg::CFG_SLOT_BYTES, flst_pkg::CfgDataW'($urandom_range(1, 4096)));
    write_reg(flst_pkg::CFG_SLOT_LIMIT, {2'b11, 11'h7FF});
    base = exhausted_seen;
    chunk = 0;
    while (exhausted_seen == base && chunk < 16) begin
      run_mix(100, idle_modes[chunk % 3], 96, 0, 1'b1);
      chunk++;
    end
    run_mix(40, 27, 50, 40, 1'b0);

    while (in_flight != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
